FILE: rtl/rmgg_pkg.sv
// ----------------------------------------------------------------------------
// rmgg_pkg
// Shared widths, limits and types for the running mean gap grouper.
// ----------------------------------------------------------------------------
package rmgg_pkg;

    localparam int TIME_W = 20;   // unsigned 12.8 time values
    localparam int SUM_W  = 36;   // group sum
    localparam int CNT_W  = 16;   // group count
    localparam int GRP_W  = 16;   // group number

    localparam logic [TIME_W-1:0] TOL_RESET       = 20'd1280;   // 5.0
    localparam logic [CNT_W-1:0]  MAX_GROUP_COUNT = 16'd65535;
    localparam logic [GRP_W-1:0]  GROUP_MAX       = 16'd65535;

    // one quotient bit per cycle
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: rtl/rmgg_div.sv
// ----------------------------------------------------------------------------
// rmgg_div
// Restoring serial divider: group sum by group count, one bit per cycle.
// ----------------------------------------------------------------------------
module rmgg_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rmgg_pkg::SUM_W-1:0]    dividend,
    input  logic [rmgg_pkg::CNT_W-1:0]    divisor,
    output rmgg_pkg::div_status_t         status,
    output logic [rmgg_pkg::TIME_W-1:0]   quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [rmgg_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [rmgg_pkg::SUM_W-1:0]        quo_reg, quo_next;
    logic [rmgg_pkg::CNT_W-1:0]        rem_reg, rem_next;
    logic [rmgg_pkg::CNT_W-1:0]        dvs_reg, dvs_next;

    logic [rmgg_pkg::CNT_W:0]          shifted;
    logic [rmgg_pkg::CNT_W+1:0]        trial;

    assign shifted = {rem_reg, quo_reg[rmgg_pkg::SUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits in CNT_W bits
            if (trial[rmgg_pkg::CNT_W+1]) begin
                rem_next = shifted[rmgg_pkg::CNT_W-1:0];
                quo_next = {quo_reg[rmgg_pkg::SUM_W-2:0], 1'b0};
            end else begin
                rem_next = trial[rmgg_pkg::CNT_W-1:0];
                quo_next = {quo_reg[rmgg_pkg::SUM_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rmgg_pkg::DIV_CNT_W'(rmgg_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg[rmgg_pkg::TIME_W-1:0];

endmodule

FILE: rtl/running_mean_gap_grouper_core.sv
// ----------------------------------------------------------------------------
// running_mean_gap_grouper_core
// Groups sorted time centers by distance from the running group mean.
// ----------------------------------------------------------------------------
// One word in, one word out. An accepted word is registered, then evaluated
// in the calc state (distance to the mean, group open, sum and count update);
// its result is captured in the result register in that state. The new mean
// comes from a serial divider that yields one quotient bit per cycle over the
// 36 bit sum, so a word that accumulates holds the block until the divider is
// done before the next word is taken; a word that hits the count limit skips
// the divider. The output register lets a finished word wait on m_ready while
// the next word is taken. The tolerance register may be written only while idle.
module running_mean_gap_grouper_core (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rmgg_pkg::TIME_W-1:0]   cfg_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rmgg_pkg::TIME_W-1:0]   s_time_center,
    input  logic                          s_start_list,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rmgg_pkg::GRP_W-1:0]    m_group_number,
    output logic                          m_opened_group,
    output logic                          m_count_overflow
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]                     state_reg, state_next;
    logic [rmgg_pkg::TIME_W-1:0]    tol_reg;

    logic [rmgg_pkg::TIME_W-1:0]    tc_reg;
    logic                           start_reg;

    logic [rmgg_pkg::TIME_W-1:0]    mean_reg, mean_next;
    logic [rmgg_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [rmgg_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [rmgg_pkg::GRP_W-1:0]     grp_reg, grp_next;
    logic                           have_reg, have_next;

    logic                           pend_reg, pend_next;
    logic [rmgg_pkg::GRP_W-1:0]     res_grp_reg;
    logic                           res_open_reg;
    logic                           res_ovf_reg;

    logic                           mv_reg;
    logic [rmgg_pkg::GRP_W-1:0]     mgrp_reg;
    logic                           mopen_reg;
    logic                           movf_reg;
    logic                           out_load;

    // evaluation of the held word
    logic [rmgg_pkg::TIME_W-1:0]    e_mean;
    logic [rmgg_pkg::SUM_W-1:0]     e_sum;
    logic [rmgg_pkg::CNT_W-1:0]     e_cnt;
    logic [rmgg_pkg::GRP_W-1:0]     e_grp;
    logic                           e_have;
    logic [rmgg_pkg::TIME_W-1:0]    dist_abs;
    logic                           open_new;
    logic                           ovf;
    logic [rmgg_pkg::SUM_W-1:0]     o_sum;
    logic [rmgg_pkg::CNT_W-1:0]     o_cnt;
    logic [rmgg_pkg::GRP_W-1:0]     o_grp;

    logic                           div_start;
    rmgg_pkg::div_status_t          div_st;
    logic [rmgg_pkg::TIME_W-1:0]    div_q;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && !pend_reg;
    assign out_load  = pend_reg && (!mv_reg || m_ready);

    always_comb begin
        // start flag clears the grouping state first
        e_mean = start_reg ? '0 : mean_reg;
        e_sum  = start_reg ? '0 : sum_reg;
        e_cnt  = start_reg ? '0 : cnt_reg;
        e_grp  = start_reg ? '0 : grp_reg;
        e_have = start_reg ? 1'b0 : have_reg;

        dist_abs = (tc_reg >= e_mean) ? (tc_reg - e_mean) : (e_mean - tc_reg);
        open_new = !e_have || (dist_abs > tol_reg);

        o_sum = open_new ? '0 : e_sum;
        o_cnt = open_new ? '0 : e_cnt;
        o_grp = (open_new && (e_grp < rmgg_pkg::GROUP_MAX)) ? e_grp + 1'b1 : e_grp;
        ovf   = (o_cnt == rmgg_pkg::MAX_GROUP_COUNT);
    end

    always_comb begin
        state_next = state_reg;
        mean_next  = mean_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        grp_next   = grp_reg;
        have_next  = have_reg;
        pend_next  = pend_reg;
        div_start  = 1'b0;

        if (out_load) begin
            pend_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                pend_next = 1'b1;
                grp_next  = o_grp;
                have_next = 1'b1;
                mean_next = e_mean;
                if (ovf) begin
                    sum_next   = o_sum;
                    cnt_next   = o_cnt;
                    state_next = ST_IDLE;
                end else begin
                    sum_next   = o_sum + {{(rmgg_pkg::SUM_W-rmgg_pkg::TIME_W){1'b0}}, tc_reg};
                    cnt_next   = o_cnt + 1'b1;
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_st.done) begin
                    mean_next  = div_q;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    rmgg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (cnt_next),
        .status   (div_st),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tol_reg   <= rmgg_pkg::TOL_RESET;
            mean_reg  <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            grp_reg   <= '0;
            have_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mean_reg  <= mean_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            grp_reg   <= grp_next;
            have_reg  <= have_next;
            pend_reg  <= pend_next;
            if (cfg_valid && cfg_ready) begin
                tol_reg <= cfg_data;
            end
            if (out_load) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end

        if (s_valid && s_ready) begin
            tc_reg    <= s_time_center;
            start_reg <= s_start_list;
        end
        if (state_reg == ST_CALC) begin
            res_grp_reg  <= o_grp;
            res_open_reg <= open_new;
            res_ovf_reg  <= ovf;
        end
        if (out_load) begin
            mgrp_reg  <= res_grp_reg;
            mopen_reg <= res_open_reg;
            movf_reg  <= res_ovf_reg;
        end
    end

    assign m_valid          = mv_reg;
    assign m_group_number   = mgrp_reg;
    assign m_opened_group   = mopen_reg;
    assign m_count_overflow = movf_reg;

endmodule

FILE: bench/tb_running_mean_gap_grouper_core.sv
// ----------------------------------------------------------------------------
// tb_running_mean_gap_grouper_core
// Self-checking bench for the running mean gap grouper core. A short directed
// list hits the tolerance boundary, unsorted values, the start flag and the
// extreme time values under the reset tolerance, zero and full scale. Random
// sorted lists with random content follow under several tolerance settings.
// An in-bench predictor tracks mean, sum, count and group number. Each output
// word is compared field by field against the oldest predicted word. Both
// channels see random gaps, and the output is held off once for a long
// stretch so that the input backs up.
// ----------------------------------------------------------------------------
module tb_running_mean_gap_grouper_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_TOP     = (1 << rmgg_pkg::TIME_W) - 1;
    localparam int SETTLE_CYC   = 45;     // divider drain after the last word
    localparam int LONG_HOLD    = 600;
    localparam int HOLD_AT_WORD = 300;
    localparam int RANDOM_WORDS = 1450;
    localparam int N_PHASES     = 8;

    typedef struct packed {
        logic [rmgg_pkg::GRP_W-1:0] group_number;
        logic                       opened_group;
        logic                       count_overflow;
    } group_word_t;

    // Tracks the open group and predicts the output word of each input word.
    class group_tracker;
        logic [rmgg_pkg::TIME_W-1:0] tol;
        logic [rmgg_pkg::TIME_W-1:0] mean;
        logic [rmgg_pkg::SUM_W-1:0]  sum;
        logic [rmgg_pkg::CNT_W-1:0]  cnt;
        logic [rmgg_pkg::GRP_W-1:0]  cur_group;
        logic                        have_group;
        group_word_t                 pending_words[$];
        int                          mismatches;
        int                          groups_opened;
        int                          overflows;

        function new();
            tol           = rmgg_pkg::TOL_RESET;
            mismatches    = 0;
            groups_opened = 0;
            overflows     = 0;
            clear();
        endfunction

        function void clear();
            mean       = '0;
            sum        = '0;
            cnt        = '0;
            cur_group  = '0;
            have_group = 1'b0;
        endfunction

        function void take_center(logic [rmgg_pkg::TIME_W-1:0] tc, logic start);
            logic [rmgg_pkg::TIME_W-1:0] gap_dist;
            group_word_t                 w;
            w = '0;
            if (start)
                clear();
            gap_dist = (tc >= mean) ? tc - mean : mean - tc;
            w.opened_group = !have_group || (gap_dist > tol);
            if (w.opened_group) begin
                if (cur_group < rmgg_pkg::GROUP_MAX)
                    cur_group++;
                sum        = '0;
                cnt        = '0;
                have_group = 1'b1;
                groups_opened++;
            end
            if (cnt < rmgg_pkg::MAX_GROUP_COUNT) begin
                sum  = sum + rmgg_pkg::SUM_W'(tc);
                cnt  = cnt + 1'b1;
                mean = rmgg_pkg::TIME_W'(sum / cnt);
            end else begin
                w.count_overflow = 1'b1;
                overflows++;
            end
            w.group_number = cur_group;
            pending_words.push_back(w);
        endfunction

        function void check_word(logic [rmgg_pkg::GRP_W-1:0] grp, logic opened, logic ovf);
            group_word_t w;
            if (pending_words.size() == 0) begin
                mismatches++;
                $display("%0t: output word with nothing expected: group %0d opened %0b ovf %0b",
                         $time, grp, opened, ovf);
                return;
            end
            w = pending_words[0];
            pending_words.delete(0);
            if (w.group_number !== grp) begin
                mismatches++;
                $display("%0t: group_number expected %0d actual %0d",
                         $time, w.group_number, grp);
            end
            if (w.opened_group !== opened) begin
                mismatches++;
                $display("%0t: opened_group expected %0b actual %0b",
                         $time, w.opened_group, opened);
            end
            if (w.count_overflow !== ovf) begin
                mismatches++;
                $display("%0t: count_overflow expected %0b actual %0b",
                         $time, w.count_overflow, ovf);
            end
        endfunction
    endclass

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [rmgg_pkg::TIME_W-1:0] cfg_data;
    logic                        s_valid;
    logic                        s_ready;
    logic [rmgg_pkg::TIME_W-1:0] s_time_center;
    logic                        s_start_list;
    logic                        m_valid;
    logic                        m_ready;
    logic [rmgg_pkg::GRP_W-1:0]  m_group_number;
    logic                        m_opened_group;
    logic                        m_count_overflow;

    group_tracker tracker;
    int           n_sent;
    int           n_settings;
    int           longest_list;
    int           tx_burst;

    running_mean_gap_grouper_core u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_time_center    (s_time_center),
        .s_start_list     (s_start_list),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_group_number   (m_group_number),
        .m_opened_group   (m_opened_group),
        .m_count_overflow (m_count_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [rmgg_pkg::TIME_W-1:0] clamp_time(input int v);
        if (v < 0)
            return '0;
        if (v > TIME_TOP)
            return TIME_TOP[rmgg_pkg::TIME_W-1:0];
        return v[rmgg_pkg::TIME_W-1:0];
    endfunction

    // mostly back to back or short, now and then long; occasional bursts
    function int next_tx_gap();
        int r;
        if (tx_burst > 0) begin
            tx_burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            tx_burst = $urandom_range(10, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 40);
        return $urandom_range(41, 150);
    endfunction

    task automatic send_center(input logic [rmgg_pkg::TIME_W-1:0] tc, input logic start);
        int gap;
        gap = next_tx_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_time_center <= tc;
        s_start_list  <= start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_center(tc, start);
        n_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (tracker.pending_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_tolerance(input logic [rmgg_pkg::TIME_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        tracker.tol = v;
        n_settings++;
    endtask

    // sorted lists with random steps around the tolerance, plus some noise
    task automatic send_random_lists(input int budget);
        int   left;
        int   len;
        int   k;
        int   tol;
        int   mean;
        logic start;
        logic [rmgg_pkg::TIME_W-1:0] prev;
        logic [rmgg_pkg::TIME_W-1:0] tc;
        left = budget;
        while (left > 0) begin
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 40)
                                                : $urandom_range(41, 250);
            if (len > left)
                len = left;
            if (len > longest_list)
                longest_list = len;
            prev = ($urandom_range(0, 99) < 70) ? clamp_time($urandom_range(0, 4095))
                                                : clamp_time($urandom_range(0, TIME_TOP));
            send_center(prev, 1'b1);
            for (int i = 1; i < len; i++) begin
                tol   = int'(tracker.tol);
                mean  = int'(tracker.mean);
                start = 1'b0;
                k     = $urandom_range(0, 99);
                if (k < 35)
                    tc = clamp_time(int'(prev) + $urandom_range(0, tol >> 2));
                else if (k < 50)
                    tc = clamp_time(mean + tol);
                else if (k < 60)
                    tc = clamp_time(mean + tol + 1);
                else if (k < 65)
                    tc = clamp_time(mean - tol);
                else if (k < 80)
                    tc = clamp_time(int'(prev) + tol + 1 + $urandom_range(0, 2 * tol));
                else if (k < 90)
                    tc = prev;
                else if (k < 96)
                    tc = clamp_time($urandom_range(0, TIME_TOP));
                else begin
                    // restart in the middle of a list
                    tc    = clamp_time($urandom_range(0, TIME_TOP));
                    start = 1'b1;
                end
                send_center(tc, start);
                prev = tc;
            end
            left -= len;
        end
    endtask

    // output side: random stalls, ready stretches, and one long hold-off
    initial begin
        int hold;
        int run;
        int r;
        bit long_done;
        hold      = 0;
        run       = 0;
        long_done = 1'b0;
        m_ready   = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (!long_done && n_sent >= HOLD_AT_WORD) begin
                long_done = 1'b1;
                hold      = LONG_HOLD;
                m_ready  <= 1'b0;
            end else if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (run > 0) begin
                run--;
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    run      = $urandom_range(50, 300);
                    m_ready <= 1'b1;
                end else if (r < 60) begin
                    m_ready <= 1'b1;
                end else if (r < 93) begin
                    hold     = $urandom_range(0, 3);
                    m_ready <= 1'b0;
                end else begin
                    hold     = $urandom_range(10, 80);
                    m_ready <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_word(m_group_number, m_opened_group, m_count_overflow);
    end

    initial begin
        logic [rmgg_pkg::TIME_W-1:0] tol_val;
        tracker       = new();
        n_sent        = 0;
        n_settings    = 1;
        longest_list  = 0;
        tx_burst      = 0;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_time_center = '0;
        s_start_list  = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset tolerance: boundary joins, openings, extremes, unsorted values
        send_center('0, 1'b1);
        send_center('0, 1'b0);
        send_center(clamp_time(int'(tracker.tol)), 1'b0);
        send_center(clamp_time(int'(tracker.mean) + int'(tracker.tol) + 1), 1'b0);
        send_center(clamp_time(int'(tracker.mean) + int'(tracker.tol)), 1'b0);
        send_center(clamp_time(int'(tracker.mean) + int'(tracker.tol) + 1), 1'b0);
        send_center(TIME_TOP[rmgg_pkg::TIME_W-1:0], 1'b0);
        send_center(TIME_TOP[rmgg_pkg::TIME_W-1:0], 1'b0);
        send_center('0, 1'b0);
        send_center(TIME_TOP[rmgg_pkg::TIME_W-1:0], 1'b1);
        send_center(20'h80000, 1'b1);
        send_center(clamp_time(int'(tracker.mean) - int'(tracker.tol)), 1'b0);
        send_center(20'h55555, 1'b0);
        send_center(20'hAAAAA, 1'b0);

        // zero tolerance: only equal values join
        write_tolerance('0);
        send_center(20'd100, 1'b1);
        send_center(20'd100, 1'b0);
        send_center(20'd101, 1'b0);
        send_center(20'd101, 1'b0);
        send_center(20'd100, 1'b0);

        // full scale tolerance: everything joins
        write_tolerance(TIME_TOP[rmgg_pkg::TIME_W-1:0]);
        send_center('0, 1'b1);
        send_center(TIME_TOP[rmgg_pkg::TIME_W-1:0], 1'b0);
        send_center('0, 1'b0);

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       tol_val = '0;
                1:       tol_val = TIME_TOP[rmgg_pkg::TIME_W-1:0];
                2:       tol_val = rmgg_pkg::TOL_RESET;
                3:       tol_val = clamp_time($urandom_range(1, 16));
                4:       tol_val = clamp_time($urandom_range(100, 5000));
                5:       tol_val = clamp_time($urandom_range(5001, 60000));
                default: tol_val = clamp_time($urandom_range(0, TIME_TOP));
            endcase
            write_tolerance(tol_val);
            send_random_lists(RANDOM_WORDS / N_PHASES);
        end

        wait_drained();
        $display("Covered %0d words in lists up to %0d long under %0d tolerance settings;",
                 n_sent, longest_list, n_settings);
        $display("%0d groups opened, %0d count overflows, one %0d cycle output hold-off.",
                 tracker.groups_opened, tracker.overflows, LONG_HOLD);
        if (tracker.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
